/* hdl/i8mm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package i8mm_pkg;

  // default capacity of the weight store
  localparam int unsigned MAX_K_DEF = 256;
  localparam int unsigned MAX_N_DEF = 16;

  // element and product widths
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned PROD_W  = 2 * VALUE_W;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned ROW_W   = 16;
  localparam int unsigned COL_W   = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned DEPTH_K_W  = 9;
  localparam int unsigned COUNT_N_W  = 5;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_K = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_N = 2'd1;

  // request opcodes
  localparam logic OP_LOAD_B   = 1'b0;
  localparam logic OP_STREAM_A = 1'b1;

endpackage
`default_nettype wire

/* hdl/i8mm_serial_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module i8mm_serial_mul (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic signed [i8mm_pkg::VALUE_W-1:0]  a_i,
  input  wire logic signed [i8mm_pkg::VALUE_W-1:0]  b_i,
  output logic                                      done_o,
  output logic signed [i8mm_pkg::PROD_W-1:0]        prod_o
);
  import i8mm_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_W);

  logic               run_q;
  logic [CW-1:0]      cnt_q;
  logic [PROD_W-1:0]  mcand_q;
  logic [VALUE_W-1:0] mplier_q;
  logic [PROD_W-1:0]  prod_q;
  logic               last_step;

  assign last_step = (cnt_q == CW'(VALUE_W - 1));
  assign done_o    = run_q & last_step;
  assign prod_o    = prod_q;

  // control: one multiplier bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last_step) run_q <= 1'b0;
    end
  end

  // shift-add datapath, sign bit carries negative weight
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= PROD_W'(a_i);
      mplier_q <= b_i;
      prod_q   <= '0;
    end else if (run_q) begin
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      if (mplier_q[0]) begin
        if (last_step) prod_q <= prod_q - mcand_q;
        else           prod_q <= prod_q + mcand_q;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/int8_matmul_int32_accumulate.sv */
`timescale 1ns / 1ps
`default_nettype none
// Signed int8 matrix product with wrapping int32 sums. Load B first with op 0
// (row-major, count_n rows of depth_k), then stream A with op 1. A B load
// leaves busy low. For each of the n columns an A element goes through one
// weight store read, one multiplier load, a run of the bit-serial multiplier
// and one accumulator update. After the element that ends a row, the n sums
// leave on consecutive cycles, each marked by valid_o for exactly one cycle;
// the receiver must take every result as it appears. Configuration writes
// are taken only while idle.
module int8_matmul_int32_accumulate #(
  parameter int unsigned MAX_K = i8mm_pkg::MAX_K_DEF,
  parameter int unsigned MAX_N = i8mm_pkg::MAX_N_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic                                   op_i,
  input  wire logic signed [i8mm_pkg::VALUE_W-1:0]    value_i,
  input  wire logic                                   wr_en_i,
  input  wire logic [i8mm_pkg::CFG_IDX_W-1:0]         wr_idx_i,
  input  wire logic [i8mm_pkg::CFG_DATA_W-1:0]        wr_data_i,
  output logic                                        valid_o,
  output logic [i8mm_pkg::ROW_W-1:0]                  row_index_o,
  output logic [i8mm_pkg::COL_W-1:0]                  column_o,
  output logic signed [i8mm_pkg::SUM_W-1:0]           sum_o,
  output logic                                        last_o
);
  import i8mm_pkg::*;

  localparam int unsigned DEPTH = MAX_K * MAX_N;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned KNW   = $clog2(DEPTH + 1);
  localparam int unsigned KW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned KCW   = $clog2(MAX_K + 1);
  localparam int unsigned NW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int unsigned NCW   = $clog2(MAX_N + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_LOAD, ST_MUL, ST_ACC, ST_EMIT, ST_DRAIN
  } state_e;

  state_e               state_q;
  logic [DEPTH_K_W-1:0] depth_k_q;
  logic [COUNT_N_W-1:0] count_n_q;
  logic [AW-1:0]        wptr_q;
  logic [KW-1:0]        kp_q;
  logic [NW-1:0]        j_q;
  logic [AW-1:0]        addr_q;
  logic [ROW_W-1:0]     row_q;
  logic [VALUE_W-1:0]   a_q;
  logic [MAX_N-1:0]     acc_vld_q;

  logic [VALUE_W-1:0]   wmem [DEPTH];
  logic [SUM_W-1:0]     amem [MAX_N];
  logic [VALUE_W-1:0]   w_rdata_q;
  logic [SUM_W-1:0]     a_rdata_q;
  logic                 a_rvld_q;

  logic                 valid_q;
  logic [COL_W-1:0]     col_q;
  logic                 last_q;
  logic [ROW_W-1:0]     orow_q;

  logic [KCW-1:0]       eff_k;
  logic [NCW-1:0]       eff_n;
  logic [KNW-1:0]       kn;
  logic                 accept;
  logic                 w_we;
  logic                 a_re;
  logic                 a_we;
  logic                 mul_start;
  logic                 mul_done;
  logic [PROD_W-1:0]    prod;
  logic [SUM_W-1:0]     acc_new;
  logic                 j_end;
  logic                 k_end;

  // effective sizes, saturated to 1..MAX
  always_comb begin
    if (depth_k_q == '0)                     eff_k = KCW'(1);
    else if (32'(depth_k_q) > 32'(MAX_K))    eff_k = KCW'(MAX_K);
    else                                     eff_k = KCW'(depth_k_q);
    if (count_n_q == '0)                     eff_n = NCW'(1);
    else if (32'(count_n_q) > 32'(MAX_N))    eff_n = NCW'(MAX_N);
    else                                     eff_n = NCW'(count_n_q);
  end

  assign kn        = KNW'(eff_k) * KNW'(eff_n);
  assign busy      = (state_q != ST_IDLE);
  assign accept    = start & ~busy;
  assign w_we      = accept & (op_i == OP_LOAD_B);
  assign a_re      = (state_q == ST_READ) | (state_q == ST_EMIT);
  assign a_we      = (state_q == ST_ACC);
  assign mul_start = (state_q == ST_LOAD);
  assign j_end     = (j_q == NW'(eff_n - 1'b1));
  assign k_end     = (kp_q == KW'(eff_k - 1'b1));
  assign acc_new   = (a_rvld_q ? a_rdata_q : '0) + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};

  i8mm_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (a_q),
    .b_i     (w_rdata_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // weight store
  always_ff @(posedge clk_i) begin
    if (w_we) wmem[wptr_q] <= value_i;
    if (state_q == ST_READ) w_rdata_q <= wmem[addr_q];
  end

  // accumulator store, cleared through valid bits
  always_ff @(posedge clk_i) begin
    if (a_we) amem[j_q] <= acc_new;
    if (a_re) begin
      a_rdata_q <= amem[j_q];
      a_rvld_q  <= acc_vld_q[j_q];
    end
  end

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      depth_k_q <= DEPTH_K_W'(256);
      count_n_q <= COUNT_N_W'(16);
      wptr_q    <= '0;
      kp_q      <= '0;
      j_q       <= '0;
      addr_q    <= '0;
      row_q     <= '0;
      acc_vld_q <= '0;
      valid_q   <= 1'b0;
      col_q     <= '0;
      last_q    <= 1'b0;
      orow_q    <= '0;
      a_q       <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (wr_en_i && (wr_idx_i == REG_DEPTH_K || wr_idx_i == REG_COUNT_N)) begin
            if (wr_idx_i == REG_DEPTH_K) depth_k_q <= wr_data_i;
            else                         count_n_q <= COUNT_N_W'(wr_data_i);
            wptr_q    <= '0;
            kp_q      <= '0;
            acc_vld_q <= '0;
          end else if (accept) begin
            if (op_i == OP_LOAD_B) begin
              if (KNW'(wptr_q) + KNW'(1) >= kn) wptr_q <= '0;
              else                              wptr_q <= wptr_q + 1'b1;
            end else begin
              a_q     <= value_i;
              j_q     <= '0;
              addr_q  <= AW'(kp_q);
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: state_q <= ST_LOAD;
        ST_LOAD: state_q <= ST_MUL;
        ST_MUL:  if (mul_done) state_q <= ST_ACC;
        ST_ACC: begin
          acc_vld_q[j_q] <= 1'b1;
          if (j_end) begin
            j_q <= '0;
            if (k_end) begin
              kp_q    <= '0;
              state_q <= ST_EMIT;
            end else begin
              kp_q    <= kp_q + 1'b1;
              state_q <= ST_IDLE;
            end
          end else begin
            j_q     <= j_q + 1'b1;
            addr_q  <= AW'(KNW'(addr_q) + KNW'(eff_k));
            state_q <= ST_READ;
          end
        end
        ST_EMIT: begin
          valid_q <= 1'b1;
          col_q   <= COL_W'(j_q);
          last_q  <= j_end;
          orow_q  <= row_q;
          if (j_end) state_q <= ST_DRAIN;
          else       j_q     <= j_q + 1'b1;
        end
        ST_DRAIN: begin
          acc_vld_q <= '0;
          row_q     <= row_q + 1'b1;
          j_q       <= '0;
          state_q   <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign valid_o     = valid_q;
  assign row_index_o = orow_q;
  assign column_o    = col_q;
  assign last_o      = last_q;
  assign sum_o       = a_rvld_q ? a_rdata_q : '0;

  // results only follow the emit phase
  a_emit_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q) == ST_EMIT))
    else $error("result outside emit phase");

  // the last mark ends the burst and the block returns to idle
  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |=> (state_q == ST_IDLE && !valid_o))
    else $error("burst did not end after last result");

  // multiplier finishes only while the sequencer waits for it
  a_mul_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL))
    else $error("multiplier done outside wait state");

endmodule
`default_nettype wire

/* bench/int8_matmul_int32_accumulate_test.sv */
`timescale 1ns / 1ps
module int8_matmul_int32_accumulate_test;
  import i8mm_pkg::*;

  typedef struct packed {
    logic       op;
    logic [7:0] value;
  } elem_req_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [SUM_W-1:0] sum;
    logic             last;
  } dot_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  op_i = OP_LOAD_B;
  logic signed [7:0]     value_i = '0;
  logic                  wr_en_i = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_idx_i = REG_DEPTH_K;
  logic [CFG_DATA_W-1:0] wr_data_i = '0;
  wire                   busy;
  wire                   valid_o;
  wire [ROW_W-1:0]       row_index_o;
  wire [COL_W-1:0]       column_o;
  wire signed [SUM_W-1:0] sum_o;
  wire                   last_o;

  int8_matmul_int32_accumulate dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .op_i(op_i), .value_i(value_i),
    .wr_en_i(wr_en_i), .wr_idx_i(wr_idx_i), .wr_data_i(wr_data_i),
    .valid_o(valid_o), .row_index_o(row_index_o), .column_o(column_o),
    .sum_o(sum_o), .last_o(last_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  elem_req_t pending_elems[$];
  dot_res_t  expected_sums[$];
  int        idle_pct = 0;
  int        mismatch_count = 0;

  // shadow of the block state
  logic [7:0]       weights [MAX_K_DEF*MAX_N_DEF];
  int unsigned      load_ptr = 0;
  logic [SUM_W-1:0] acc [MAX_N_DEF];
  int unsigned      k_pos = 0;
  logic [ROW_W-1:0] row_count = '0;
  logic [8:0]       depth_reg = 9'd256;
  logic [4:0]       count_reg = 5'd16;

  function automatic int unsigned eff_depth();
    if (depth_reg < 1) return 1;
    if (depth_reg > MAX_K_DEF) return MAX_K_DEF;
    return depth_reg;
  endfunction

  function automatic int unsigned eff_count();
    if (count_reg < 1) return 1;
    if (count_reg > MAX_N_DEF) return MAX_N_DEF;
    return count_reg;
  endfunction

  task automatic restart_streams();
    load_ptr = 0;
    k_pos = 0;
    for (int j = 0; j < MAX_N_DEF; j++) acc[j] = '0;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_DEPTH_K: begin
        depth_reg = data[8:0];
        restart_streams();
      end
      REG_COUNT_N: begin
        count_reg = data[4:0];
        restart_streams();
      end
      default: ;
    endcase
  endtask

  // update shadow state for one accepted request and queue any sums
  task automatic predict_dot(input elem_req_t r);
    int unsigned k;
    int unsigned n;
    logic signed [31:0] a;
    logic signed [31:0] b;
    dot_res_t res;
    k = eff_depth();
    n = eff_count();
    if (r.op == OP_LOAD_B) begin
      weights[load_ptr] = r.value;
      load_ptr++;
      if (load_ptr >= k * n) load_ptr = 0;
    end else begin
      a = signed'(r.value);
      for (int j = 0; j < n; j++) begin
        b = signed'(weights[j * k + k_pos]);
        acc[j] = acc[j] + a * b;
      end
      k_pos++;
      if (k_pos >= k) begin
        for (int j = 0; j < n; j++) begin
          res.row = row_count;
          res.col = j[COL_W-1:0];
          res.sum = acc[j];
          res.last = (j + 1 == n);
          expected_sums.push_back(res);
          acc[j] = '0;
        end
        k_pos = 0;
        row_count = row_count + 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // driver
  always @(posedge clk_i) begin : drive_blk
    elem_req_t nxt;
    if (rst_ni) begin
      if (start && !busy) predict_dot('{op: op_i, value: value_i});
      if (!start || !busy) begin
        if (pending_elems.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_elems.pop_front();
          op_i <= nxt.op;
          value_i <= nxt.value;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch_blk
    dot_res_t exp_r;
    if (rst_ni && valid_o) begin
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected sum row %0d col %0d", row_index_o, column_o));
      end else begin
        exp_r = expected_sums.pop_front();
        if (row_index_o !== exp_r.row)
          report_mismatch($sformatf("row %0d, want %0d", row_index_o, exp_r.row));
        if (column_o !== exp_r.col)
          report_mismatch($sformatf("column %0d, want %0d", column_o, exp_r.col));
        if (sum_o !== exp_r.sum)
          report_mismatch($sformatf("sum %0d, want %0d", sum_o, $signed(exp_r.sum)));
        if (last_o !== exp_r.last)
          report_mismatch($sformatf("last %0b, want %0b", last_o, exp_r.last));
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    wr_en_i <= 1'b1;
    wr_idx_i <= idx;
    wr_data_i <= data;
    @(posedge clk_i);
    wr_en_i <= 1'b0;
    apply_write(idx, data);
  endtask

  task automatic push_elem(input logic op, input logic [7:0] v);
    pending_elems.push_back('{op: op, value: v});
  endtask

  // fill every weight of the current shape
  task automatic push_weights();
    for (int i = 0; i < eff_depth() * eff_count(); i++) push_elem(OP_LOAD_B, 8'($urandom));
  endtask

  task automatic push_mixed(input int cnt);
    for (int i = 0; i < cnt; i++)
      push_elem(($urandom_range(99) < 80) ? OP_STREAM_A : OP_LOAD_B, 8'($urandom));
  endtask

  // wait until all requests are in and all sums are out, then settle
  task automatic drain();
    while (pending_elems.size() != 0 || start || expected_sums.size() != 0 || busy)
      @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  int shape_k [7] = '{4, 1, 7, 2, 6, 3, 5};
  int shape_n [7] = '{3, 31, 1, 5, 4, 2, 8};
  int idle_mix [3] = '{0, 78, 11};

  // main sequence
  initial begin
    for (int i = 0; i < MAX_K_DEF*MAX_N_DEF; i++) weights[i] = '0;
    restart_streams();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero registers act as one, loads wrap, loading after a row
    write_reg(REG_DEPTH_K, 9'd0);
    write_reg(REG_COUNT_N, 9'd0);
    push_elem(OP_LOAD_B, 8'h80);
    push_elem(OP_STREAM_A, 8'h80);
    push_elem(OP_STREAM_A, 8'h7f);
    push_elem(OP_STREAM_A, 8'hff);
    push_elem(OP_LOAD_B, 8'h7f);
    push_elem(OP_STREAM_A, 8'h80);
    drain();

    // unknown indexes are ignored
    write_reg(2'd2, 9'h1ff);
    write_reg(2'd3, 9'h1ff);
    write_reg(REG_DEPTH_K, 9'd3);
    write_reg(REG_COUNT_N, 9'd2);
    push_elem(OP_LOAD_B, 8'h7f);
    push_elem(OP_LOAD_B, 8'h80);
    push_elem(OP_LOAD_B, 8'hff);
    push_elem(OP_LOAD_B, 8'h00);
    push_elem(OP_LOAD_B, 8'h01);
    push_elem(OP_LOAD_B, 8'h80);
    push_elem(OP_STREAM_A, 8'h80);
    push_elem(OP_STREAM_A, 8'h7f);
    push_elem(OP_STREAM_A, 8'h80);
    push_elem(OP_STREAM_A, 8'h7f);
    // weight reload in the middle of a row
    push_elem(OP_LOAD_B, 8'h80);
    push_elem(OP_STREAM_A, 8'h7f);
    push_elem(OP_STREAM_A, 8'h7f);
    drain();

    // random phases over several shapes and idle rates
    for (int p = 0; p < 7; p++) begin
      idle_pct = idle_mix[p % 3];
      write_reg(REG_DEPTH_K, 9'(shape_k[p]));
      write_reg(REG_COUNT_N, 9'(shape_n[p]));
      push_weights();
      push_mixed(24);
      drain();
    end

    // out-of-range depth saturates, a partial row makes no sums
    idle_pct = 11;
    write_reg(REG_DEPTH_K, 9'h1ff);
    write_reg(REG_COUNT_N, 9'd1);
    for (int i = 0; i < 4; i++) push_elem(OP_LOAD_B, 8'($urandom));
    for (int i = 0; i < 4; i++) push_elem(OP_STREAM_A, 8'($urandom));
    drain();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // timeout
  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

endmodule
